// ===== hw/rtl/pfc32_pkg.sv =====
// Package for the packet framer: framing constants, output slot codes and the CRC-32 byte update.
package pfc32_pkg;

    // Field widths fixed by the interface
    localparam int unsigned BYTE_W     = 8;
    localparam int unsigned LEN_PORT_W = 16;
    localparam int unsigned SIZE_W     = 12;
    localparam int unsigned CRC_W      = 32;

    // Payload size handling
    localparam logic [SIZE_W-1:0] PAYLOAD_RESET = 12'd1024;
    localparam logic [SIZE_W-1:0] PAYLOAD_MIN   = 12'd1;
    localparam logic [SIZE_W-1:0] PAYLOAD_MAX   = 12'd4091;
    localparam logic [SIZE_W-1:0] HDR_OVERHEAD  = 12'd4;

    // Reflected IEEE CRC-32
    localparam logic [CRC_W-1:0] CRC_POLY = 32'hEDB8_8320;
    localparam logic [CRC_W-1:0] CRC_INIT = 32'hFFFF_FFFF;

    // Position of a word within the burst that one input word causes
    typedef logic [3:0] slot_t;
    localparam slot_t SLOT_HDR0 = 4'd0;
    localparam slot_t SLOT_HDR1 = 4'd1;
    localparam slot_t SLOT_HDR2 = 4'd2;
    localparam slot_t SLOT_HDR3 = 4'd3;
    localparam slot_t SLOT_DATA = 4'd4;
    localparam slot_t SLOT_CRC0 = 4'd5;
    localparam slot_t SLOT_CRC1 = 4'd6;
    localparam slot_t SLOT_CRC2 = 4'd7;
    localparam slot_t SLOT_CRC3 = 4'd8;

    // One byte through the bitwise CRC-32 update
    function automatic logic [CRC_W-1:0] crc_byte(input logic [CRC_W-1:0] crc_in,
                                                  input logic [BYTE_W-1:0] data);
        logic [CRC_W-1:0] crc;
        crc = crc_in ^ {{(CRC_W-BYTE_W){1'b0}}, data};
        for (int k = 0; k < BYTE_W; k++) begin
            if (crc[0]) begin
                crc = (crc >> 1) ^ CRC_POLY;
            end else begin
                crc = crc >> 1;
            end
        end
        return crc;
    endfunction

endpackage

// ===== hw/rtl/packet_framer_crc32_top.sv =====
// Packet framer top level: length header, payload bytes and trailing CRC-32 per packet.
//
//  channel | ports                                           | direction
//  --------+-------------------------------------------------+----------
//  input   | s_valid s_ready s_mode s_data_byte              | in
//          | s_message_length                                |
//  result  | m_valid m_ready m_out_byte m_packet_start m_last| out
//  config  | cfg_wr_en cfg_wr_data (payload_size)            | in
//
// Each input word is folded into the framing state in the cycle it is accepted and
// lands in a burst register; the burst of 1, 5 or 9 words is then sent at one word
// per cycle, held in place by a stall on m_ready. A new input word is taken in the
// cycle the last word of the burst leaves, so a plain payload byte makes a one-word
// burst and a packet boundary up to nine words. Words that cause no result (end of
// stream, anything after it) make no burst. Reset (aresetn low, synchronous) empties
// the burst register, clears the framing state and sets payload_size to 1024.
module packet_framer_crc32_top #(
    parameter int unsigned MSG_LEN_BITS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration
    input  logic        cfg_wr_en,
    input  logic [11:0] cfg_wr_data,
    // input words
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_mode,
    input  logic [7:0]  s_data_byte,
    input  logic [15:0] s_message_length,
    // framed output
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_out_byte,
    output logic        m_packet_start,
    output logic        m_last
);

    localparam int unsigned LEN_W = (MSG_LEN_BITS < pfc32_pkg::LEN_PORT_W) ?
                                    MSG_LEN_BITS : pfc32_pkg::LEN_PORT_W;
    localparam int unsigned CMP_W = (LEN_W > pfc32_pkg::SIZE_W) ? LEN_W : pfc32_pkg::SIZE_W;
    localparam int unsigned SW    = pfc32_pkg::SIZE_W;

    // Framing state
    logic [SW-1:0]               payload_size_reg;
    logic [LEN_W-1:0]            msg_left_reg,  msg_left_next;
    logic [SW-1:0]               pkt_left_reg,  pkt_left_next;
    logic [pfc32_pkg::CRC_W-1:0] crc_reg,       crc_next;
    logic                        done_reg,      done_next;

    // Burst register
    logic                        burst_valid_reg, burst_valid_next;
    pfc32_pkg::slot_t            slot_reg,        slot_next;
    pfc32_pkg::slot_t            end_slot_reg,    end_slot_next;
    logic [SW-1:0]               cnt_reg,         cnt_next;
    logic [7:0]                  data_reg,        data_next;
    logic [pfc32_pkg::CRC_W-1:0] fcs_reg,         fcs_next;

    logic burst_end;
    logic in_take;

    // Word leaves and frees the slot
    assign burst_end = burst_valid_reg && m_ready && (slot_reg == end_slot_reg);
    assign s_ready   = !burst_valid_reg || burst_end;
    assign in_take   = s_valid && s_ready;

    // Per-word framing step
    always_comb begin
        logic [LEN_W-1:0]            len;
        logic [LEN_W-1:0]            msg_cur;
        logic [SW-1:0]               pkt_cur;
        logic [SW-1:0]               ps_eff;
        logic [SW-1:0]               pkt_len;
        logic [SW-1:0]               pkt_use;
        logic [pfc32_pkg::CRC_W-1:0] crc_base;
        logic [pfc32_pkg::CRC_W-1:0] crc_new;
        logic                        new_msg;
        logic                        start_pkt;
        logic                        pkt_end;

        len     = s_message_length[LEN_W-1:0];
        new_msg = (msg_left_reg == '0);
        msg_cur = new_msg ? len : msg_left_reg;
        pkt_cur = new_msg ? '0 : pkt_left_reg;
        start_pkt = (pkt_cur == '0);

        // clamp the configured size
        if (payload_size_reg == '0) begin
            ps_eff = pfc32_pkg::PAYLOAD_MIN;
        end else if (payload_size_reg > pfc32_pkg::PAYLOAD_MAX) begin
            ps_eff = pfc32_pkg::PAYLOAD_MAX;
        end else begin
            ps_eff = payload_size_reg;
        end

        if (CMP_W'(msg_cur) < CMP_W'(ps_eff)) begin
            pkt_len = SW'(msg_cur);
        end else begin
            pkt_len = ps_eff;
        end
        pkt_use  = start_pkt ? pkt_len : pkt_cur;
        crc_base = start_pkt ? pfc32_pkg::CRC_INIT : crc_reg;
        crc_new  = pfc32_pkg::crc_byte(crc_base, s_data_byte);
        pkt_end  = (pkt_use == SW'(1));

        msg_left_next    = msg_left_reg;
        pkt_left_next    = pkt_left_reg;
        crc_next         = crc_reg;
        done_next        = done_reg;
        burst_valid_next = burst_valid_reg && !burst_end;
        slot_next        = slot_reg;
        end_slot_next    = end_slot_reg;
        cnt_next         = cnt_reg;
        data_next        = data_reg;
        fcs_next         = fcs_reg;

        // step through the burst
        if (burst_valid_reg && m_ready && !burst_end) begin
            slot_next = slot_reg + pfc32_pkg::slot_t'(1);
        end

        if (in_take && !done_reg) begin
            if (s_mode || (new_msg && (len == '0))) begin
                // end of stream, explicit or by zero length
                done_next = 1'b1;
            end else begin
                msg_left_next    = msg_cur - LEN_W'(1);
                pkt_left_next    = pkt_use - SW'(1);
                crc_next         = pkt_end ? pfc32_pkg::CRC_INIT : crc_new;
                burst_valid_next = 1'b1;
                slot_next        = start_pkt ? pfc32_pkg::SLOT_HDR0 : pfc32_pkg::SLOT_DATA;
                end_slot_next    = pkt_end ? pfc32_pkg::SLOT_CRC3 : pfc32_pkg::SLOT_DATA;
                cnt_next         = pkt_len + pfc32_pkg::HDR_OVERHEAD;
                data_next        = s_data_byte;
                fcs_next         = ~crc_new;
            end
        end
    end

    // Control and state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            payload_size_reg <= pfc32_pkg::PAYLOAD_RESET;
            msg_left_reg     <= '0;
            pkt_left_reg     <= '0;
            crc_reg          <= pfc32_pkg::CRC_INIT;
            done_reg         <= 1'b0;
            burst_valid_reg  <= 1'b0;
            slot_reg         <= pfc32_pkg::SLOT_DATA;
        end else begin
            if (cfg_wr_en) begin
                payload_size_reg <= cfg_wr_data;
            end
            msg_left_reg    <= msg_left_next;
            pkt_left_reg    <= pkt_left_next;
            crc_reg         <= crc_next;
            done_reg        <= done_next;
            burst_valid_reg <= burst_valid_next;
            slot_reg        <= slot_next;
        end
    end

    // Burst payload, no reset
    always_ff @(posedge aclk) begin
        end_slot_reg <= end_slot_next;
        cnt_reg      <= cnt_next;
        data_reg     <= data_next;
        fcs_reg      <= fcs_next;
    end

    // Output word select
    always_comb begin
        case (slot_reg)
            pfc32_pkg::SLOT_HDR0, pfc32_pkg::SLOT_HDR2:
                m_out_byte = {4'h0, cnt_reg[11:8]};
            pfc32_pkg::SLOT_HDR1, pfc32_pkg::SLOT_HDR3:
                m_out_byte = cnt_reg[7:0];
            pfc32_pkg::SLOT_CRC0: m_out_byte = fcs_reg[31:24];
            pfc32_pkg::SLOT_CRC1: m_out_byte = fcs_reg[23:16];
            pfc32_pkg::SLOT_CRC2: m_out_byte = fcs_reg[15:8];
            pfc32_pkg::SLOT_CRC3: m_out_byte = fcs_reg[7:0];
            default:              m_out_byte = data_reg;
        endcase
    end

    assign m_valid        = burst_valid_reg;
    assign m_packet_start = (slot_reg == pfc32_pkg::SLOT_HDR0);
    assign m_last         = (slot_reg == end_slot_reg);

endmodule

// ===== verif/packet_framer_checker.sv =====
// Checker for the packet framer: predicts the framed byte stream and compares it word by word.
module packet_framer_checker #(
    parameter int unsigned MSG_LEN_BITS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [11:0] cfg_wr_data,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic        s_mode,
    input  logic [7:0]  s_data_byte,
    input  logic [15:0] s_message_length,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic [7:0]  m_out_byte,
    input  logic        m_packet_start,
    input  logic        m_last,
    output int          error_count,
    output int          pending_words,
    output int          words_checked,
    output int          packets_checked
);

    typedef struct packed {
        logic [pfc32_pkg::BYTE_W-1:0] value;
        logic                         start;
        logic                         last;
    } framed_word_t;

    // Framed words still owed by the block, oldest first
    framed_word_t expected_words[$];

    // Mirror of the framing state
    logic [pfc32_pkg::SIZE_W-1:0] size_reg;
    logic [31:0]                  msg_remaining;
    logic [pfc32_pkg::SIZE_W-1:0] pkt_remaining;
    logic [pfc32_pkg::CRC_W-1:0]  crc_acc;
    logic                         stopped;

    // Reflected CRC-32, one bit of the byte per step
    function automatic logic [pfc32_pkg::CRC_W-1:0] crc32_next(
            input logic [pfc32_pkg::CRC_W-1:0] c,
            input logic [pfc32_pkg::BYTE_W-1:0] b);
        logic [pfc32_pkg::CRC_W-1:0] r;
        r = c;
        for (int i = 0; i < pfc32_pkg::BYTE_W; i++) begin
            r = (r >> 1) ^ ((r[0] ^ b[i]) ? pfc32_pkg::CRC_POLY : '0);
        end
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got_v,
                                   input logic [31:0] want_v);
        $display("[%0t] framer mismatch: %s got 0x%0h expected 0x%0h",
                 $time, what, got_v, want_v);
        error_count++;
    endtask

    // Fold one accepted input word into the state and queue the words it causes
    task automatic frame_input(input logic mode, input logic [7:0] data,
                               input logic [15:0] len_in);
        framed_word_t                 burst[$];
        framed_word_t                 w;
        logic [31:0]                  len;
        logic [pfc32_pkg::SIZE_W-1:0] eff;
        logic [pfc32_pkg::SIZE_W-1:0] cnt;
        logic [pfc32_pkg::CRC_W-1:0]  fcs;
        if (stopped) return;
        if (mode) begin
            stopped = 1'b1;
            return;
        end
        // first byte of a message carries its length; zero closes the stream
        if (msg_remaining == 0) begin
            len = 32'(len_in) & 32'((64'd1 << MSG_LEN_BITS) - 64'd1);
            if (len == 0) begin
                stopped = 1'b1;
                return;
            end
            msg_remaining = len;
            pkt_remaining = '0;
        end
        // packet opens: clamp the size register, send the doubled length header
        if (pkt_remaining == 0) begin
            if (size_reg == 0) eff = pfc32_pkg::PAYLOAD_MIN;
            else if (size_reg > pfc32_pkg::PAYLOAD_MAX) eff = pfc32_pkg::PAYLOAD_MAX;
            else eff = size_reg;
            pkt_remaining = (msg_remaining < 32'(eff)) ?
                            msg_remaining[pfc32_pkg::SIZE_W-1:0] : eff;
            crc_acc = pfc32_pkg::CRC_INIT;
            cnt = pkt_remaining + pfc32_pkg::HDR_OVERHEAD;
            burst.push_back('{value: {4'h0, cnt[11:8]}, start: 1'b1, last: 1'b0});
            burst.push_back('{value: cnt[7:0], start: 1'b0, last: 1'b0});
            burst.push_back('{value: {4'h0, cnt[11:8]}, start: 1'b0, last: 1'b0});
            burst.push_back('{value: cnt[7:0], start: 1'b0, last: 1'b0});
        end
        burst.push_back('{value: data, start: 1'b0, last: 1'b0});
        crc_acc = crc32_next(crc_acc, data);
        pkt_remaining--;
        msg_remaining--;
        // packet closes: big-endian inverted CRC
        if (pkt_remaining == 0) begin
            fcs = ~crc_acc;
            burst.push_back('{value: fcs[31:24], start: 1'b0, last: 1'b0});
            burst.push_back('{value: fcs[23:16], start: 1'b0, last: 1'b0});
            burst.push_back('{value: fcs[15:8], start: 1'b0, last: 1'b0});
            burst.push_back('{value: fcs[7:0], start: 1'b0, last: 1'b0});
            crc_acc = pfc32_pkg::CRC_INIT;
        end
        foreach (burst[i]) begin
            w = burst[i];
            w.last = (i == burst.size() - 1);
            expected_words.push_back(w);
        end
    endtask

    // Watch both channels and the config port at every edge
    always @(posedge aclk) begin : watch
        framed_word_t want;
        if (!aresetn) begin
            size_reg      = pfc32_pkg::PAYLOAD_RESET;
            msg_remaining = '0;
            pkt_remaining = '0;
            crc_acc       = pfc32_pkg::CRC_INIT;
            stopped       = 1'b0;
            expected_words.delete();
        end else begin
            if (m_valid && m_ready) begin
                if (expected_words.size() == 0) begin
                    report_mismatch("word with none expected, byte", 32'(m_out_byte), 0);
                end else begin
                    want = expected_words.pop_front();
                    if (m_out_byte !== want.value)
                        report_mismatch("out_byte", 32'(m_out_byte), 32'(want.value));
                    if (m_packet_start !== want.start)
                        report_mismatch("packet_start", 32'(m_packet_start), 32'(want.start));
                    if (m_last !== want.last)
                        report_mismatch("last", 32'(m_last), 32'(want.last));
                    words_checked++;
                    if (want.start) packets_checked++;
                end
            end
            if (s_valid && s_ready) frame_input(s_mode, s_data_byte, s_message_length);
            if (cfg_wr_en) size_reg = cfg_wr_data;
        end
        pending_words = expected_words.size();
    end

endmodule

// ===== verif/packet_framer_crc32_top_tb.sv =====
// Testbench top for the packet framer: clock, reset, stimulus and the final verdict.
module packet_framer_crc32_top_tb;

    localparam int RANDOM_ITEMS  = 330;
    localparam int SETTLE_CYCLES = 12;
    localparam int DRAIN_CYCLES  = 20;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int IDLE_PCT      = 27;

    logic        aclk;
    logic        aresetn;
    logic        cfg_wr_en;
    logic [11:0] cfg_wr_data;
    logic        s_valid;
    logic        s_ready;
    logic        s_mode;
    logic [7:0]  s_data_byte;
    logic [15:0] s_message_length;
    logic        m_valid;
    logic        m_ready;
    logic [7:0]  m_out_byte;
    logic        m_packet_start;
    logic        m_last;

    int error_count;
    int pending_words;
    int words_checked;
    int packets_checked;

    logic  no_gaps;
    int    items_sent;
    int    size_writes;
    int    cycle_count;
    string stream_close;

    packet_framer_crc32_top #(
        .MSG_LEN_BITS (16)
    ) u_top (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_wr_data      (cfg_wr_data),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_mode           (s_mode),
        .s_data_byte      (s_data_byte),
        .s_message_length (s_message_length),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_out_byte       (m_out_byte),
        .m_packet_start   (m_packet_start),
        .m_last           (m_last)
    );

    packet_framer_checker #(
        .MSG_LEN_BITS (16)
    ) u_checker (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_wr_data      (cfg_wr_data),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_mode           (s_mode),
        .s_data_byte      (s_data_byte),
        .s_message_length (s_message_length),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_out_byte       (m_out_byte),
        .m_packet_start   (m_packet_start),
        .m_last           (m_last),
        .error_count      (error_count),
        .pending_words    (pending_words),
        .words_checked    (words_checked),
        .packets_checked  (packets_checked)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d words still owed", cycle_count,
                     pending_words);
            $display("** packet_framer_crc32_top: FAILED **");
            $finish;
        end
    end

    // Receiver stalls at random outside the quiet stretch
    always @(posedge aclk) begin
        m_ready <= no_gaps || ($urandom_range(0, 99) >= IDLE_PCT);
    end

    // Offer one input word and hold it until taken; valid is left high afterwards
    task automatic send_word(input logic mode, input logic [7:0] data,
                             input logic [15:0] len);
        logic took;
        while (!no_gaps && $urandom_range(0, 99) < IDLE_PCT) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid          <= 1'b1;
        s_mode           <= mode;
        s_data_byte      <= data;
        s_message_length <= len;
        do begin
            @(negedge aclk);
            took = s_ready;
            @(posedge aclk);
        end while (!took);
        items_sent++;
    endtask

    // First byte carries the length; later bytes carry random, ignored lengths
    task automatic send_message(input int len);
        for (int i = 0; i < len; i++) begin
            send_word(1'b0, 8'($urandom), (i == 0) ? 16'(len) : 16'($urandom));
        end
    endtask

    // Size register is only touched once the block has drained
    task automatic write_payload_size(input logic [11:0] value);
        s_valid <= 1'b0;
        do @(negedge aclk); while (pending_words != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        size_writes++;
    endtask

    function automatic int pick_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 80) return $urandom_range(1, 12);
        if (r < 95) return $urandom_range(13, 40);
        return $urandom_range(41, 90);
    endfunction

    function automatic logic [11:0] pick_size(input int phase);
        int r;
        // extremes first, then mostly small sizes
        if (phase == 0) return pfc32_pkg::PAYLOAD_MAX;
        if (phase == 1) return 12'hFFF;
        if (phase == 2) return 12'd3;
        r = $urandom_range(0, 99);
        if (r < 70) return 12'($urandom_range(1, 8));
        if (r < 85) return 12'($urandom_range(0, 4095));
        if (r < 90) return 12'd0;
        if (r < 95) return pfc32_pkg::PAYLOAD_MAX;
        return 12'($urandom_range(4092, 4095));
    endfunction

    initial begin : stimulus
        int phase;
        s_valid          <= 1'b0;
        s_mode           <= 1'b0;
        s_data_byte      <= '0;
        s_message_length <= '0;
        cfg_wr_en        <= 1'b0;
        cfg_wr_data      <= '0;
        no_gaps          <= 1'b0;
        aresetn          <= 1'b0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: shortest message at the reset size
        send_word(1'b0, 8'h00, 16'd1);
        // lengths on later bytes are ignored, zero included
        send_word(1'b0, 8'hFF, 16'd3);
        send_word(1'b0, 8'hA5, 16'hFFFF);
        send_word(1'b0, 8'h5A, 16'h0000);
        // size zero behaves as one byte per packet
        write_payload_size(12'd0);
        send_word(1'b0, 8'h80, 16'd2);
        send_word(1'b0, 8'h01, 16'h1234);
        write_payload_size(pfc32_pkg::PAYLOAD_MIN);
        send_word(1'b0, 8'h7E, 16'd1);
        // message split into two full packets and a short one
        write_payload_size(12'd2);
        for (int i = 0; i < 5; i++) begin
            send_word(1'b0, 8'h31 + 8'(i), (i == 0) ? 16'd5 : 16'($urandom));
        end

        // Random phases of whole messages, each at its own size
        phase = 0;
        while (items_sent < RANDOM_ITEMS) begin
            no_gaps <= (items_sent >= 140 && items_sent < 230);
            write_payload_size(pick_size(phase));
            repeat ($urandom_range(2, 5)) send_message(pick_length());
            phase++;
        end
        no_gaps <= 1'b0;

        // Close the stream one way or the other
        if ($urandom_range(0, 1) == 1) begin
            // oversized setting clamps; the open packet gets no CRC at end of stream
            write_payload_size(12'($urandom_range(4092, 4095)));
            send_word(1'b0, 8'($urandom), 16'hFFFF);
            repeat (3) send_word(1'b0, 8'($urandom), 16'($urandom));
            send_word(1'b1, 8'($urandom), 16'($urandom));
            stream_close = "end-of-stream word mid-packet";
        end else begin
            send_message(pick_length());
            send_word(1'b0, 8'($urandom), 16'h0000);
            stream_close = "zero-length message";
        end
        // everything after the close must be swallowed
        repeat (6) send_word(1'($urandom), 8'($urandom), 16'($urandom));
        s_valid <= 1'b0;

        do @(negedge aclk); while (pending_words != 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Sent %0d input words across %0d size settings; stream closed by %s.",
                 items_sent, size_writes, stream_close);
        $display("Checked %0d framed words in %0d packets, %0d mismatches.",
                 words_checked, packets_checked, error_count);
        if (error_count == 0) begin
            $display("** packet_framer_crc32_top: PASSED **");
        end else begin
            $display("** packet_framer_crc32_top: FAILED **");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
hw/rtl/pfc32_pkg.sv
hw/rtl/packet_framer_crc32_top.sv
verif/packet_framer_checker.sv
verif/packet_framer_crc32_top_tb.sv
